FILE: design/bbn_pkg.sv
// ----------------------------------------------------------------------------
// Bounding box normalizer package
// Shared constants, register indexes, status codes and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package bbn_pkg;

	localparam int unsigned BBN_STORE_DEPTH = 64;

	localparam int unsigned DIVIDEND_W = 64;
	localparam int unsigned DIVISOR_W  = 32;

	localparam logic [30:0] SIZE_RESET = 31'd65536;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DEGEN    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_HEIGHTS = 1'b1;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: design/bbn_div.sv
// ----------------------------------------------------------------------------
// Bounding box normalizer divider
// Restoring unsigned divider, one quotient bit per cycle over the dividend width.
// ----------------------------------------------------------------------------
`default_nettype none

module bbn_div
	import bbn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic               fits;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

FILE: design/bounding_box_normalizer_top.sv
// ----------------------------------------------------------------------------
// Bounding box normalizer
// Loads points and block heights, then rescales each stored entry in load order.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | in
//  in      | in_valid in_ready kind x y z_low z_high       | in
//          | last_item                                    |
//  out     | out_valid out_ready out_kind out_x out_y     | out
//          | out_z_low out_z_high status last_result      |
//
//  Loading accepts one item per cycle while in_valid is high. After the item
//  marked last, each stored entry is scaled by two 64-step passes of the shared
//  divider, or skips the divider altogether when its range is degenerate.
//  in_ready is low from the last item until the final result is registered.
//  A stalled out channel holds the sequencer in its emit step.
//  Reset clears the run state and loads 1.0 into the size registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_box_normalizer_top
	import bbn_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = BBN_STORE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic signed [31:0] z_low,
	input  logic signed [31:0] z_high,
	input  logic               last_item,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_kind,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z_low,
	output logic signed [31:0] out_z_high,
	output logic [1:0]         status,
	output logic               last_result
);

	localparam int unsigned CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int unsigned IDX_W   = $clog2(STORE_DEPTH);
	localparam int unsigned ENTRY_W = 65;

	typedef enum logic [2:0] {
		S_LOAD,
		S_READ,
		S_OPND,
		S_PROD,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [30:0] size_x_q;
	logic [30:0] size_y_q;
	logic [30:0] size_z_q;

	logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic signed [31:0] min_x_q;
	logic signed [31:0] min_y_q;
	logic signed [31:0] max_x_q;
	logic signed [31:0] max_y_q;
	logic signed [31:0] top_q;

	logic [CNT_W-1:0] idx_q;
	logic             sel_q;
	logic             deg_q;
	logic             neg_q;
	logic [31:0]      op_q;
	logic [30:0]      mul_q;
	logic [31:0]      divisor_q;
	logic [30:0]      half_q;
	logic [31:0]      res_a_q;
	logic [31:0]      res_b_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic signed [31:0] out_z_low_q;
	logic signed [31:0] out_z_high_q;
	logic [1:0]         status_q;
	logic               last_q;

	logic             accept;
	logic             full;
	logic             emit;
	logic [31:0]      rx;
	logic [31:0]      ry;
	logic             pdeg;
	logic             zdeg;
	logic             rd_kind;
	logic [31:0]      rd_first;
	logic [31:0]      rd_second;
	logic [31:0]      opnd_v;
	logic             opnd_deg;
	logic             opnd_neg;
	logic [31:0]      opnd_op;
	logic [30:0]      opnd_mul;
	logic [31:0]      opnd_div;
	logic [62:0]      product;
	logic [31:0]      fixed;
	logic [CNT_W-1:0] idx_next;
	logic             is_last;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_LOAD);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(STORE_DEPTH));
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign rx   = max_x_q - min_x_q;
	assign ry   = max_y_q - min_y_q;
	assign pdeg = (max_x_q <= min_x_q) || (max_y_q <= min_y_q);
	assign zdeg = (top_q <= 32'sd0);

	assign rd_kind   = rd_q[64];
	assign rd_first  = rd_q[63:32];
	assign rd_second = rd_q[31:0];

	assign idx_next = idx_q + 1'b1;
	assign is_last  = (idx_next == count_q);

	always_comb begin
		opnd_v = sel_q ? rd_second : rd_first;
		if (rd_kind == KIND_POINT) begin
			opnd_deg = pdeg;
			opnd_neg = 1'b0;
			opnd_op  = opnd_v - (sel_q ? min_y_q : min_x_q);
			opnd_mul = sel_q ? size_y_q : size_x_q;
			opnd_div = sel_q ? ry : rx;
		end else begin
			opnd_deg = zdeg;
			opnd_neg = opnd_v[31];
			opnd_op  = opnd_v[31] ? (32'd0 - opnd_v) : opnd_v;
			opnd_mul = size_z_q;
			opnd_div = top_q;
		end
	end

	assign product = op_q * mul_q;

	assign div_req.start    = (state_q == S_PROD);
	assign div_req.dividend = {1'b0, product};
	assign div_req.divisor  = divisor_q;

	bbn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (rd_kind == KIND_POINT) begin
			fixed = div_rsp.quotient[31:0] - {1'b0, half_q};
		end else if (neg_q) begin
			fixed = (div_rsp.quotient > 64'h8000_0000) ? 32'h8000_0000 :
				(32'd0 - div_rsp.quotient[31:0]);
		end else begin
			fixed = (div_rsp.quotient > 64'h7fff_ffff) ? 32'h7fff_ffff :
				div_rsp.quotient[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			store_mem[count_q[IDX_W-1:0]] <= (kind == KIND_POINT) ?
				{kind, x, y} : {kind, z_low, z_high};
		end
		rd_q <= store_mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			min_x_q      <= 32'sh7fff_ffff;
			min_y_q      <= 32'sh7fff_ffff;
			max_x_q      <= 32'sh8000_0000;
			max_y_q      <= 32'sh8000_0000;
			top_q        <= '0;
			idx_q        <= '0;
			sel_q        <= 1'b0;
			deg_q        <= 1'b0;
			neg_q        <= 1'b0;
			op_q         <= '0;
			mul_q        <= '0;
			divisor_q    <= '0;
			half_q       <= '0;
			res_a_q      <= '0;
			res_b_q      <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= 1'b0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_z_low_q  <= '0;
			out_z_high_q <= '0;
			status_q     <= STATUS_OK;
			last_q       <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (!full) begin
							count_q <= count_q + 1'b1;
							if (kind == KIND_POINT) begin
								if (x < min_x_q) min_x_q <= x;
								if (y < min_y_q) min_y_q <= y;
								if (x > max_x_q) max_x_q <= x;
								if (y > max_y_q) max_y_q <= y;
							end else if (z_high > top_q) begin
								top_q <= z_high;
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							idx_q   <= '0;
							sel_q   <= 1'b0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_OPND;
				end
				S_OPND: begin
					deg_q     <= opnd_deg;
					neg_q     <= opnd_neg;
					op_q      <= opnd_op;
					mul_q     <= opnd_mul;
					divisor_q <= opnd_div;
					half_q    <= {1'b0, opnd_mul[30:1]};
					if (opnd_deg) begin
						res_a_q <= '0;
						res_b_q <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (!sel_q) begin
							res_a_q <= fixed;
							sel_q   <= 1'b1;
							state_q <= S_OPND;
						end else begin
							res_b_q <= fixed;
							sel_q   <= 1'b0;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (emit) begin
						out_kind_q   <= rd_kind;
						out_x_q      <= (rd_kind == KIND_POINT) ? res_a_q : '0;
						out_y_q      <= (rd_kind == KIND_POINT) ? res_b_q : '0;
						out_z_low_q  <= (rd_kind == KIND_HEIGHTS) ? res_a_q : '0;
						out_z_high_q <= (rd_kind == KIND_HEIGHTS) ? res_b_q : '0;
						status_q     <= ovf_q ? STATUS_OVERFLOW :
							(deg_q ? STATUS_DEGEN : STATUS_OK);
						last_q       <= is_last;
						if (is_last) begin
							// drop the run state for the next set
							count_q <= '0;
							ovf_q   <= 1'b0;
							min_x_q <= 32'sh7fff_ffff;
							min_y_q <= 32'sh7fff_ffff;
							max_x_q <= 32'sh8000_0000;
							max_y_q <= 32'sh8000_0000;
							top_q   <= '0;
							idx_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_next;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z_low   = out_z_low_q;
	assign out_z_high  = out_z_high_q;
	assign status      = status_q;
	assign last_result = last_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAIT))
		else $error("divider result outside wait step");

	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_item) |=> !in_ready)
		else $error("input still open after last transaction");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |=> (count_q == CNT_W'(STORE_DEPTH)) && ovf_q)
		else $error("store overflow not tracked");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Bounding box normalizer testbench
// Loads sets of points and block heights through the input channel and
// predicts every scaled result in load order from an in-bench model of the
// box tracking, the axis mapping and the height scaling. Results are checked
// field by field as they leave the block. A directed run covers the value
// extremes, flat boxes, non-positive tops and saturation. Random sets follow
// under several size settings, with and without random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import bbn_pkg::*;

	localparam int DEPTH = BBN_STORE_DEPTH;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 300;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z_lo;
		logic [31:0] z_hi;
		logic        is_last;
		logic        hold;
	} load_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] zl;
		logic [31:0] zh;
		logic [1:0]  status;
		logic        fin;
	} norm_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_SIZE_X;
	logic [30:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               kind = KIND_POINT;
	logic signed [31:0] x = '0;
	logic signed [31:0] y = '0;
	logic signed [31:0] z_low = '0;
	logic signed [31:0] z_high = '0;
	logic               last_item = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               out_kind;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z_low;
	logic signed [31:0] out_z_high;
	logic [1:0]         status;
	logic               last_result;

	load_item_t   load_queue[$];
	norm_result_t scaled_due[$];
	load_item_t   item_on_bus;

	int sender_idle_pct = 8;
	int receiver_idle_pct = 69;
	int error_count = 0;
	int results_checked = 0;
	int quiet_cycles = 0;

	logic [30:0]        width_q;
	logic [30:0]        depth_q;
	logic [30:0]        height_q;
	logic               slot_kind[DEPTH];
	logic [31:0]        slot_a[DEPTH];
	logic [31:0]        slot_b[DEPTH];
	int                 slot_fill;
	logic               slot_spill;
	logic signed [31:0] lo_x;
	logic signed [31:0] lo_y;
	logic signed [31:0] hi_x;
	logic signed [31:0] hi_y;
	logic signed [31:0] peak_z;

	bounding_box_normalizer_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.x          (x),
		.y          (y),
		.z_low      (z_low),
		.z_high     (z_high),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (out_kind),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z_low  (out_z_low),
		.out_z_high (out_z_high),
		.status     (status),
		.last_result(last_result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task clear_run();
		slot_fill = 0;
		slot_spill = 1'b0;
		lo_x = 32'sh7FFFFFFF;
		lo_y = 32'sh7FFFFFFF;
		hi_x = 32'sh80000000;
		hi_y = 32'sh80000000;
		peak_z = '0;
	endtask

	function automatic logic [31:0] fit_axis(logic [31:0] v, logic [31:0] lo,
			logic [31:0] span, logic [30:0] size);
		logic [63:0] q;
		q = ({32'd0, v - lo} * {33'd0, size}) / {32'd0, span};
		return q[31:0] - {2'b00, size[30:1]};
	endfunction

	function automatic logic [31:0] scale_z(logic [31:0] z);
		longint p;
		longint t;
		longint q;
		p = longint'($signed(z)) * longint'({33'd0, height_q});
		t = peak_z;
		q = p / t;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	task absorb_item(input load_item_t it);
		logic [31:0]  span_x;
		logic [31:0]  span_y;
		logic         flat_box;
		logic         flat_top;
		logic         degen;
		norm_result_t r;
		if (slot_fill < DEPTH) begin
			slot_kind[slot_fill] = it.kind;
			if (it.kind == KIND_POINT) begin
				slot_a[slot_fill] = it.x;
				slot_b[slot_fill] = it.y;
				if ($signed(it.x) < lo_x)
					lo_x = it.x;
				if ($signed(it.y) < lo_y)
					lo_y = it.y;
				if ($signed(it.x) > hi_x)
					hi_x = it.x;
				if ($signed(it.y) > hi_y)
					hi_y = it.y;
			end else begin
				slot_a[slot_fill] = it.z_lo;
				slot_b[slot_fill] = it.z_hi;
				if ($signed(it.z_hi) > peak_z)
					peak_z = it.z_hi;
			end
			slot_fill++;
		end else begin
			slot_spill = 1'b1;
		end
		if (it.is_last) begin
			span_x = hi_x - lo_x;
			span_y = hi_y - lo_y;
			flat_box = (hi_x <= lo_x) || (hi_y <= lo_y);
			flat_top = (peak_z <= 0);
			for (int i = 0; i < slot_fill; i++) begin
				r = '0;
				r.kind = slot_kind[i];
				r.fin = (i == slot_fill - 1);
				if (r.kind == KIND_POINT) begin
					degen = flat_box;
					if (!degen) begin
						r.px = fit_axis(slot_a[i], lo_x, span_x, width_q);
						r.py = fit_axis(slot_b[i], lo_y, span_y, depth_q);
					end
				end else begin
					degen = flat_top;
					if (!degen) begin
						r.zl = scale_z(slot_a[i]);
						r.zh = scale_z(slot_b[i]);
					end
				end
				r.status = slot_spill ? STATUS_OVERFLOW : (degen ? STATUS_DEGEN : STATUS_OK);
				scaled_due.push_back(r);
			end
			clear_run();
		end
	endtask

	task note_mismatch(input string msg);
		if (error_count < 100)
			$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	task check_word(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("result %0d %s got %h want %h",
				results_checked, name, got, want));
	endtask

	task compare_result(input norm_result_t want);
		check_word("out_kind", {31'd0, out_kind}, {31'd0, want.kind});
		check_word("out_x", out_x, want.px);
		check_word("out_y", out_y, want.py);
		check_word("out_z_low", out_z_low, want.zl);
		check_word("out_z_high", out_z_high, want.zh);
		check_word("status", {30'd0, status}, {30'd0, want.status});
		check_word("last_result", {31'd0, last_result}, {31'd0, want.fin});
		results_checked++;
	endtask

	// driver: hold valid and payload until the transaction completes
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				absorb_item(item_on_bus);
			if (!in_valid || in_ready) begin
				if (load_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct
						&& !(load_queue[0].hold && scaled_due.size() != 0)) begin
					item_on_bus = load_queue.pop_front();
					in_valid <= 1'b1;
					kind <= item_on_bus.kind;
					x <= item_on_bus.x;
					y <= item_on_bus.y;
					z_low <= item_on_bus.z_lo;
					z_high <= item_on_bus.z_hi;
					last_item <= item_on_bus.is_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (scaled_due.size() == 0)
					note_mismatch("result transaction with nothing expected");
				else
					compare_result(scaled_due.pop_front());
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("bounding_box_normalizer_top verification failed");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	task push_item(input logic k, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] zl, input logic [31:0] zh, input logic fin, input logic hold);
		load_item_t it;
		it.kind = k;
		it.x = px;
		it.y = py;
		it.z_lo = zl;
		it.z_hi = zh;
		it.is_last = fin;
		it.hold = hold;
		load_queue.push_back(it);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2, 3: return $urandom_range(0, 32'h00140000) - 32'h000A0000;
			4: return 32'h7FFFFFFF;
			5: return 32'h80000000;
			6: return $urandom_range(0, 1000);
			default: return ($urandom >> $urandom_range(0, 31)) ^ {32{1'($urandom_range(0, 1))}};
		endcase
	endfunction

	task queue_random_set(input int count);
		int          flavor;
		logic        k;
		logic        flat_x;
		logic        flat_y;
		logic        low_tops;
		logic        hold;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] zh;
		flavor = $urandom_range(0, 9);
		flat_x = ($urandom_range(0, 9) == 0);
		flat_y = ($urandom_range(0, 9) == 0);
		low_tops = ($urandom_range(0, 6) == 0);
		hold = ($urandom_range(0, 6) == 0);
		fx = pick_coord();
		fy = pick_coord();
		for (int i = 0; i < count; i++) begin
			if (flavor == 0)
				k = KIND_POINT;
			else if (flavor == 1)
				k = KIND_HEIGHTS;
			else
				k = 1'($urandom_range(0, 1));
			zh = low_tops ? 32'd0 - $urandom_range(0, 32'h00050000) : pick_coord();
			push_item(k, flat_x ? fx : pick_coord(), flat_y ? fy : pick_coord(),
				pick_coord(), zh, i == count - 1, hold && i == 0);
		end
	endtask

	task settle();
		do @(posedge clk);
		while (load_queue.size() != 0 || in_valid || scaled_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task program_size(input logic [1:0] idx, input logic [30:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SIZE_X: width_q = val;
			REG_SIZE_Y: depth_q = val;
			REG_SIZE_Z: height_q = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int budget;
		int n;
		int r;
		clear_run();
		width_q = SIZE_RESET;
		depth_q = SIZE_RESET;
		height_q = SIZE_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_item(KIND_POINT, 32'h80000000, 32'h80000000, $urandom, $urandom, 1'b0, 1'b0);
		push_item(KIND_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, $urandom, $urandom, 1'b0, 1'b0);
		push_item(KIND_HEIGHTS, $urandom, $urandom, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0);
		push_item(KIND_POINT, 32'h00010000, 32'hFFFF0000, $urandom, $urandom, 1'b1, 1'b0);
		// flat x with only negative tops
		push_item(KIND_POINT, 32'h00030000, 32'h00000000, $urandom, $urandom, 1'b0, 1'b1);
		push_item(KIND_POINT, 32'h00030000, 32'h00050000, $urandom, $urandom, 1'b0, 1'b0);
		push_item(KIND_HEIGHTS, $urandom, $urandom, 32'hFFFE0000, 32'hFFFF0000, 1'b1, 1'b0);
		push_item(KIND_HEIGHTS, $urandom, $urandom, 32'hFFFB0000, 32'h00000000, 1'b1, 1'b0);
		// tiny top drives the low height of both items into saturation
		push_item(KIND_HEIGHTS, $urandom, $urandom, 32'h7FFFFFFF, 32'h00000002, 1'b0, 1'b0);
		push_item(KIND_HEIGHTS, $urandom, $urandom, 32'h80000000, 32'h00000001, 1'b1, 1'b0);
		push_item(KIND_POINT, 32'hFFFF0000, 32'h00000000, $urandom, $urandom, 1'b0, 1'b0);
		push_item(KIND_HEIGHTS, $urandom, $urandom, 32'h00010000, 32'h00020000, 1'b0, 1'b0);
		push_item(KIND_POINT, 32'h00010000, 32'h00030000, $urandom, $urandom, 1'b1, 1'b0);
		push_item(KIND_POINT, 32'h00010000, 32'h00070000, $urandom, $urandom, 1'b0, 1'b0);
		push_item(KIND_POINT, 32'h00050000, 32'h00070000, $urandom, $urandom, 1'b1, 1'b0);
		push_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b0);

		for (int s = 0; s < 6; s++) begin
			if (s > 0) begin
				settle();
				case (s)
					1: begin
						program_size(REG_SIZE_X, 31'h7FFFFFFF);
						program_size(REG_SIZE_Y, 31'd0);
						program_size(REG_SIZE_Z, 31'h7FFFFFFF);
					end
					3: begin
						program_size(REG_SIZE_X, 31'd0);
						program_size(REG_SIZE_Y, 31'h7FFFFFFF);
						program_size(REG_SIZE_Z, 31'd0);
						program_size(REG_UNUSED, 31'($urandom));
					end
					4: begin
						program_size(REG_SIZE_X, 31'($urandom_range(1, 32'h00FF0000)));
						program_size(REG_SIZE_Y, 31'($urandom_range(1, 32'h00FF0000)));
						program_size(REG_SIZE_Z, 31'($urandom_range(1, 32'h00FF0000)));
					end
					default: begin
						program_size(REG_SIZE_X, 31'($urandom));
						program_size(REG_SIZE_Y, 31'($urandom));
						program_size(REG_SIZE_Z, 31'($urandom));
					end
				endcase
			end
			sender_idle_pct = (s < 2) ? 8 : ((s < 4) ? 69 : 0);
			receiver_idle_pct = (s < 2) ? 69 : ((s < 4) ? 8 : 0);
			budget = 0;
			// full store sets: one past depth, exactly depth, well past depth
			if (s == 1 || s == 3 || s == 5) begin
				n = (s == 1) ? DEPTH + 1 : ((s == 3) ? DEPTH : DEPTH + 6);
				queue_random_set(n);
				budget += n;
			end
			while (budget < 20) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					n = $urandom_range(1, 8);
				else if (r < 95)
					n = $urandom_range(9, 24);
				else
					n = $urandom_range(60, 70);
				queue_random_set(n);
				budget += n;
			end
		end

		settle();
		if (error_count == 0)
			$display("bounding_box_normalizer_top verification clean");
		else
			$display("bounding_box_normalizer_top verification failed");
		$finish;
	end

endmodule
